[rtl/core/bcdrtc_pkg.sv]
// shared types, register map and bcd helpers for the rtc register file
package bcdrtc_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = $clog2(REG_COUNT);

   typedef logic [7:0] byte_type;
   typedef logic [REG_COUNT-1:0][7:0] regs_type;

   // request kinds
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_TICK  = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_YEAR_LOCATION = 2'd0,
      CSR_YEAR_BASE80   = 2'd1,
      CSR_YEAR_BCD      = 2'd2,
      CSR_IRQ_PRESENT   = 2'd3
   } csr_index_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   // year slot codes
   localparam logic [1:0] YLOC_REG_LOW  = 2'd1;
   localparam logic [1:0] YLOC_REG_HIGH = 2'd2;

   typedef struct packed {
      logic [1:0] year_location;
      logic       year_base80;
      logic       year_bcd;
      logic       irq_present;
   } cfg_type;

   // register map
   localparam logic [REG_IDX_W-1:0] REG_SECONDS     = 5'd2;
   localparam logic [REG_IDX_W-1:0] REG_MINUTES     = 5'd3;
   localparam logic [REG_IDX_W-1:0] REG_HOURS       = 5'd4;
   localparam logic [REG_IDX_W-1:0] REG_WEEKDAY     = 5'd5;
   localparam logic [REG_IDX_W-1:0] REG_DAY         = 5'd6;
   localparam logic [REG_IDX_W-1:0] REG_MONTH       = 5'd7;
   localparam logic [REG_IDX_W-1:0] REG_COUNTER_LAST = 5'd7;
   localparam logic [REG_IDX_W-1:0] REG_ALARM_BASE  = 5'd8;
   localparam logic [REG_IDX_W-1:0] REG_YEAR_LOW    = 5'd9;
   localparam logic [REG_IDX_W-1:0] REG_ALARM_CMP_FIRST = 5'd10;
   localparam logic [REG_IDX_W-1:0] REG_YEAR_HIGH   = 5'd14;
   localparam logic [REG_IDX_W-1:0] REG_ALARM_LAST  = 5'd15;
   localparam logic [REG_IDX_W-1:0] REG_STATUS      = 5'd16;
   localparam logic [REG_IDX_W-1:0] REG_CONTROL     = 5'd17;
   localparam logic [REG_IDX_W-1:0] REG_RESET_CNT   = 5'd18;
   localparam logic [REG_IDX_W-1:0] REG_RESET_RAM   = 5'd19;
   localparam logic [REG_IDX_W-1:0] REG_RSVD_A      = 5'd20;
   localparam logic [REG_IDX_W-1:0] REG_RSVD_B      = 5'd21;
   localparam logic [REG_IDX_W-1:0] REG_RSVD_C      = 5'd22;
   localparam logic [REG_IDX_W-1:0] REG_RSVD_D      = 5'd31;

   // interrupt causes, also the control enable bits
   localparam byte_type CAUSE_ALARM  = 8'h01;
   localparam byte_type CAUSE_SECOND = 8'h04;
   localparam byte_type CAUSE_MINUTE = 8'h08;
   localparam byte_type CAUSE_HOUR   = 8'h10;
   localparam byte_type CAUSE_DAY    = 8'h20;
   localparam byte_type CAUSE_WEEK   = 8'h40;
   localparam byte_type CAUSE_MONTH  = 8'h80;

   localparam byte_type CMD_RESET      = 8'hFF;
   localparam byte_type ALARM_ANY_MASK = 8'hC0;
   localparam byte_type SEC_LIMIT      = 8'h60;
   localparam byte_type MIN_LIMIT      = 8'h60;
   localparam byte_type HOUR_LIMIT     = 8'h24;
   localparam byte_type WEEKDAY_LAST   = 8'h07;
   localparam byte_type MONTH_LAST     = 8'h12;
   localparam byte_type DATE_FIRST     = 8'h01;
   localparam byte_type YEAR_BCD_80    = 8'h80;
   localparam byte_type YEAR_BIN_80    = 8'd80;

   // hi*10 + lo, invalid digits included
   function automatic byte_type bcd_dec(input byte_type b);
      return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
   endfunction

   // add one digit-wise: a low digit of 9 or more drops by 9 and carries into the high digit
   function automatic byte_type bcd_inc(input byte_type b);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b[7:4];
      lo = b[3:0];
      if (lo >= 4'd9) begin
         return {hi + 4'd1, lo - 4'd9};
      end else begin
         return {hi, lo + 4'd1};
      end
   endfunction

   // encode 0..99 as two bcd digits
   function automatic byte_type bcd_enc_small(input logic [6:0] n);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(n) * 15'd205;
      tens = prod[14:11];
      ones = n - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
      return {tens, ones[3:0]};
   endfunction

   function automatic logic [4:0] month_len(input byte_type mon, input logic leap);
      case (mon)
         8'd2: begin
            return leap ? 5'd29 : 5'd28;
         end
         8'd4, 8'd6, 8'd9, 8'd11: begin
            return 5'd30;
         end
         default: begin
            return 5'd31;
         end
      endcase
   endfunction

endpackage

[rtl/core/bcdrtc_tick.sv]
// one-second tick: bcd carry cascade, calendar, year slot and alarm compare
module bcdrtc_tick (
   input  bcdrtc_pkg::regs_type regs,
   input  bcdrtc_pkg::cfg_type  cfg,
   output bcdrtc_pkg::regs_type tick_regs,
   output logic                 cause_hit
);

   bcdrtc_pkg::byte_type ctl;
   bcdrtc_pkg::byte_type cause;
   bcdrtc_pkg::byte_type year_byte;
   bcdrtc_pkg::byte_type year_dec;
   bcdrtc_pkg::byte_type year_mod;
   bcdrtc_pkg::byte_type year_store;
   logic [8:0]           year_off;
   logic [8:0]           year_next;
   logic                 slot_valid;
   logic [bcdrtc_pkg::REG_IDX_W-1:0] slot_idx;
   logic                 leap;
   logic                 alarm_all;

   assign ctl = regs[bcdrtc_pkg::REG_CONTROL];

   always_comb begin
      slot_valid = 1'b0;
      slot_idx   = bcdrtc_pkg::REG_YEAR_LOW;
      case (cfg.year_location)
         bcdrtc_pkg::YLOC_REG_LOW: begin
            slot_valid = 1'b1;
            slot_idx   = bcdrtc_pkg::REG_YEAR_LOW;
         end
         bcdrtc_pkg::YLOC_REG_HIGH: begin
            slot_valid = 1'b1;
            slot_idx   = bcdrtc_pkg::REG_YEAR_HIGH;
         end
         default: begin
            slot_valid = 1'b0;
            slot_idx   = bcdrtc_pkg::REG_YEAR_LOW;
         end
      endcase
   end

   // year offset from 1900; 1900 is a multiple of 400 minus 100, so only
   // offsets 0, 200 and 300 are century non-leap years in range
   assign year_byte = (cfg.year_location == bcdrtc_pkg::YLOC_REG_HIGH)
                      ? regs[bcdrtc_pkg::REG_YEAR_HIGH] : regs[bcdrtc_pkg::REG_YEAR_LOW];
   assign year_dec  = cfg.year_bcd ? bcdrtc_pkg::bcd_dec(year_byte) : year_byte;
   assign year_off  = slot_valid ? (9'(year_dec) + (cfg.year_base80 ? 9'd80 : 9'd0)) : 9'd80;
   assign leap      = (year_off[1:0] == 2'b00) && (year_off != 9'd0) &&
                      (year_off != 9'd200) && (year_off != 9'd300);

   // advance: stored value plus one, modulo 100
   assign year_next = 9'(year_dec) + 9'd1;
   always_comb begin
      if (year_next >= 9'd200) begin
         year_mod = 8'(year_next - 9'd200);
      end else if (year_next >= 9'd100) begin
         year_mod = 8'(year_next - 9'd100);
      end else begin
         year_mod = year_next[7:0];
      end
   end
   assign year_store = cfg.year_bcd ? bcdrtc_pkg::bcd_enc_small(year_mod[6:0]) : year_mod;

   always_comb begin
      tick_regs = regs;
      cause     = '0;
      alarm_all = 1'b1;

      tick_regs[bcdrtc_pkg::REG_SECONDS] = bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_SECONDS]);
      if ((ctl & bcdrtc_pkg::CAUSE_SECOND) != '0) cause = bcdrtc_pkg::CAUSE_SECOND;
      if (tick_regs[bcdrtc_pkg::REG_SECONDS] >= bcdrtc_pkg::SEC_LIMIT) begin
         tick_regs[bcdrtc_pkg::REG_SECONDS] = '0;
         tick_regs[bcdrtc_pkg::REG_MINUTES] =
            bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_MINUTES]);
         if ((ctl & bcdrtc_pkg::CAUSE_MINUTE) != '0) cause = bcdrtc_pkg::CAUSE_MINUTE;
         if (tick_regs[bcdrtc_pkg::REG_MINUTES] >= bcdrtc_pkg::MIN_LIMIT) begin
            tick_regs[bcdrtc_pkg::REG_MINUTES] = '0;
            tick_regs[bcdrtc_pkg::REG_HOURS] = bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_HOURS]);
            if ((ctl & bcdrtc_pkg::CAUSE_HOUR) != '0) cause = bcdrtc_pkg::CAUSE_HOUR;
            if (tick_regs[bcdrtc_pkg::REG_HOURS] >= bcdrtc_pkg::HOUR_LIMIT) begin
               tick_regs[bcdrtc_pkg::REG_HOURS] = '0;
               tick_regs[bcdrtc_pkg::REG_WEEKDAY] =
                  bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_WEEKDAY]);
               if ((ctl & bcdrtc_pkg::CAUSE_DAY) != '0) cause = bcdrtc_pkg::CAUSE_DAY;
               if (tick_regs[bcdrtc_pkg::REG_WEEKDAY] > bcdrtc_pkg::WEEKDAY_LAST) begin
                  tick_regs[bcdrtc_pkg::REG_WEEKDAY] = bcdrtc_pkg::DATE_FIRST;
                  if ((ctl & bcdrtc_pkg::CAUSE_WEEK) != '0) cause = bcdrtc_pkg::CAUSE_WEEK;
               end
               tick_regs[bcdrtc_pkg::REG_DAY] = bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_DAY]);
               // day length comes from the month before it advances
               if (bcdrtc_pkg::bcd_dec(tick_regs[bcdrtc_pkg::REG_DAY]) >
                   8'(bcdrtc_pkg::month_len(bcdrtc_pkg::bcd_dec(regs[bcdrtc_pkg::REG_MONTH]),
                                            leap))) begin
                  tick_regs[bcdrtc_pkg::REG_DAY] = bcdrtc_pkg::DATE_FIRST;
                  tick_regs[bcdrtc_pkg::REG_MONTH] =
                     bcdrtc_pkg::bcd_inc(regs[bcdrtc_pkg::REG_MONTH]);
                  if ((ctl & bcdrtc_pkg::CAUSE_MONTH) != '0) cause = bcdrtc_pkg::CAUSE_MONTH;
                  if (tick_regs[bcdrtc_pkg::REG_MONTH] > bcdrtc_pkg::MONTH_LAST) begin
                     tick_regs[bcdrtc_pkg::REG_MONTH] = bcdrtc_pkg::DATE_FIRST;
                     if (slot_valid) begin
                        tick_regs[slot_idx] = year_store;
                     end
                  end
               end
            end
         end
      end

      // alarm compare overrides the rollover cause
      if ((ctl & bcdrtc_pkg::CAUSE_ALARM) != '0) begin
         for (int a = int'(bcdrtc_pkg::REG_ALARM_CMP_FIRST);
              a <= int'(bcdrtc_pkg::REG_ALARM_LAST); a++) begin
            if (!(slot_valid && (bcdrtc_pkg::REG_IDX_W'(a) == slot_idx))) begin
               if (!((tick_regs[bcdrtc_pkg::REG_IDX_W'(a - int'(bcdrtc_pkg::REG_ALARM_BASE))] ==
                      tick_regs[bcdrtc_pkg::REG_IDX_W'(a)]) ||
                     ((tick_regs[bcdrtc_pkg::REG_IDX_W'(a)] & bcdrtc_pkg::ALARM_ANY_MASK) ==
                      bcdrtc_pkg::ALARM_ANY_MASK))) begin
                  alarm_all = 1'b0;
               end
            end
         end
         cause = alarm_all ? bcdrtc_pkg::CAUSE_ALARM : '0;
      end

      cause_hit = (cause != '0);
      if (cause_hit) begin
         tick_regs[bcdrtc_pkg::REG_STATUS] = cause;
      end
   end

endmodule

[rtl/core/bcd_rtc_alarm_registers.sv]
// top level: request register, rtc register file and response register
//
//  channel  ports              payload                                  handshake
//  request  req_*              req_type, req_reg_offset, req_write_data valid / stall
//  response rsp_*              rsp_read_data, rsp_irq_raise, rsp_irq_clear valid / stall
//  config   csr_*              csr_index, csr_write_data                write enable
//
// a request is captured in the input register, then one pass of logic
// updates the 32-byte register file and loads the response register.
// one request per cycle is sustained while the response is not stalled. reset
// clears the register file, the config and both valid flags. response stall
// holds the response and, through it, the input register, which then stalls
// the request side.
module bcd_rtc_alarm_registers (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [bcdrtc_pkg::REG_IDX_W-1:0]    req_reg_offset,
   input  logic [7:0]                          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_irq_raise,
   output logic                                rsp_irq_clear,
   input  logic                                csr_write_enable,
   input  logic [bcdrtc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bcdrtc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic                                in_valid_ff, in_valid_in;
   logic [1:0]                          in_kind_ff;
   logic [bcdrtc_pkg::REG_IDX_W-1:0]    in_offset_ff;
   bcdrtc_pkg::byte_type                in_data_ff;
   logic                                req_accept;
   logic                                proceed;

   bcdrtc_pkg::cfg_type                 cfg_ff, cfg_in;
   bcdrtc_pkg::regs_type                regs_ff, regs_in;
   bcdrtc_pkg::regs_type                tick_regs;
   logic                                tick_hit;

   logic                                rsp_valid_ff, rsp_valid_in;
   bcdrtc_pkg::byte_type                rsp_read_data_ff, rd_in;
   logic                                rsp_irq_raise_ff, raise_in;
   logic                                rsp_irq_clear_ff, clear_in;

   // the input register moves on when the response register is free
   assign proceed    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !proceed;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_kind_ff   <= req_type;
         in_offset_ff <= req_reg_offset;
         in_data_ff   <= req_write_data;
      end
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (bcdrtc_pkg::csr_index_type'(csr_index))
            bcdrtc_pkg::CSR_YEAR_LOCATION: cfg_in.year_location = csr_write_data[1:0];
            bcdrtc_pkg::CSR_YEAR_BASE80:   cfg_in.year_base80   = csr_write_data[0];
            bcdrtc_pkg::CSR_YEAR_BCD:      cfg_in.year_bcd      = csr_write_data[0];
            bcdrtc_pkg::CSR_IRQ_PRESENT:   cfg_in.irq_present   = csr_write_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcdrtc_tick u_tick (
      .regs      (regs_ff),
      .cfg       (cfg_ff),
      .tick_regs (tick_regs),
      .cause_hit (tick_hit)
   );

   // register file update and response
   always_comb begin
      regs_in  = regs_ff;
      rd_in    = '0;
      raise_in = 1'b0;
      clear_in = 1'b0;
      if (proceed) begin
         case (in_kind_ff)
            bcdrtc_pkg::REQ_READ: begin
               rd_in = regs_ff[in_offset_ff];
               if (in_offset_ff == bcdrtc_pkg::REG_STATUS) begin
                  regs_in[bcdrtc_pkg::REG_STATUS] = '0;
                  clear_in = cfg_ff.irq_present;
               end
            end
            bcdrtc_pkg::REQ_WRITE: begin
               case (in_offset_ff)
                  bcdrtc_pkg::REG_STATUS, bcdrtc_pkg::REG_RSVD_A, bcdrtc_pkg::REG_RSVD_B,
                  bcdrtc_pkg::REG_RSVD_C, bcdrtc_pkg::REG_RSVD_D: begin
                     regs_in = regs_ff;
                  end
                  bcdrtc_pkg::REG_CONTROL: begin
                     regs_in[bcdrtc_pkg::REG_STATUS]  = '0;
                     regs_in[bcdrtc_pkg::REG_CONTROL] = in_data_ff;
                  end
                  bcdrtc_pkg::REG_RESET_CNT: begin
                     if (in_data_ff == bcdrtc_pkg::CMD_RESET) begin
                        for (int i = 0; i <= int'(bcdrtc_pkg::REG_COUNTER_LAST); i++) begin
                           regs_in[bcdrtc_pkg::REG_IDX_W'(i)] = '0;
                        end
                        regs_in[bcdrtc_pkg::REG_WEEKDAY] = bcdrtc_pkg::DATE_FIRST;
                        regs_in[bcdrtc_pkg::REG_DAY]     = bcdrtc_pkg::DATE_FIRST;
                        regs_in[bcdrtc_pkg::REG_MONTH]   = bcdrtc_pkg::DATE_FIRST;
                     end
                  end
                  bcdrtc_pkg::REG_RESET_RAM: begin
                     if (in_data_ff == bcdrtc_pkg::CMD_RESET) begin
                        for (int i = int'(bcdrtc_pkg::REG_ALARM_BASE);
                             i <= int'(bcdrtc_pkg::REG_ALARM_LAST); i++) begin
                           regs_in[bcdrtc_pkg::REG_IDX_W'(i)] = '0;
                        end
                        regs_in[bcdrtc_pkg::REG_WEEKDAY] = bcdrtc_pkg::DATE_FIRST;
                        regs_in[bcdrtc_pkg::REG_DAY]     = bcdrtc_pkg::DATE_FIRST;
                        regs_in[bcdrtc_pkg::REG_MONTH]   = bcdrtc_pkg::DATE_FIRST;
                        // year slot restarts at 1980
                        if (cfg_ff.year_location == bcdrtc_pkg::YLOC_REG_LOW ||
                            cfg_ff.year_location == bcdrtc_pkg::YLOC_REG_HIGH) begin
                           regs_in[(cfg_ff.year_location == bcdrtc_pkg::YLOC_REG_HIGH)
                                   ? bcdrtc_pkg::REG_YEAR_HIGH : bcdrtc_pkg::REG_YEAR_LOW] =
                              cfg_ff.year_base80 ? 8'h00 :
                              (cfg_ff.year_bcd ? bcdrtc_pkg::YEAR_BCD_80
                                               : bcdrtc_pkg::YEAR_BIN_80);
                        end
                     end
                  end
                  default: begin
                     regs_in[in_offset_ff] = in_data_ff;
                  end
               endcase
            end
            bcdrtc_pkg::REQ_TICK: begin
               regs_in  = tick_regs;
               raise_in = tick_hit && cfg_ff.irq_present;
            end
            default: begin
               regs_in = regs_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proceed) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (proceed) begin
         rsp_read_data_ff <= rd_in;
         rsp_irq_raise_ff <= raise_in;
         rsp_irq_clear_ff <= clear_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_irq_raise = rsp_irq_raise_ff;
   assign rsp_irq_clear = rsp_irq_clear_ff;

endmodule
